FILE: src/pwlwt_pkg.sv
package pwlwt_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CURVE_NOMINAL = 2'd0,
        CURVE_PLUS    = 2'd1,
        CURVE_MINUS   = 2'd2,
        CURVE_INVALID = 2'd3
    } t_curve;

    typedef enum logic [1:0] {
        STATUS_IN_RANGE = 2'd0,
        STATUS_OUTSIDE  = 2'd1,
        STATUS_EMPTY    = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] entry_center;
        logic [31:0] initial_amount;
        logic [31:0] nominal_target;
        logic [31:0] plus_target;
        logic [31:0] minus_target;
        logic [31:0] query_mass;
        logic [1:0]  curve_select;
    } t_in_word;

    typedef struct packed {
        logic [31:0] weight_value;
        logic [1:0]  lookup_status;
    } t_out_word;

endpackage

FILE: src/pwlwt_if.sv
interface pwlwt_in_if;
    logic                 valid;
    logic                 ready;
    pwlwt_pkg::t_in_word  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pwlwt_out_if;
    logic                 valid;
    logic                 ready;
    pwlwt_pkg::t_out_word payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/pwlwt_ram.sv
module pwlwt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: src/piecewise_linear_weight_table_unit.sv
// Piecewise-linear weight table. Append words store a center and three weights
// computed by one shared restoring divider (target * 65536 / initial, one
// quotient bit per cycle, once per curve with setup and store). Queries read the
// first and last centers, run a lower-bound binary search (up to log2 of the
// entry count plus one probes), read the two bracketing entries, then reuse the
// same divider for the interpolation offset between a product and a final add,
// unless the query equals a stored center. Clear only resets the entry count;
// empty or out-of-range queries skip the search and emit a status directly. One
// word is handled at a time; a finished result waits in the output register
// while the next word is taken, and the next result waits until that register
// is free. Tables live in four single-port-read RAMs; no clearing pass.
module piecewise_linear_weight_table_unit #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pwlwt_in_if.sink        i_in,
    pwlwt_out_if.source     o_out
);
    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_DIV_SETUP, S_DIV_RUN, S_DIV_STORE, S_WRITE,
        S_RD_FIRST, S_WAIT_FIRST, S_CHK_FIRST, S_WAIT_LAST, S_CHK_LAST,
        S_PROBE, S_PROBE_WAIT, S_PROBE_CHK,
        S_RD_HI, S_WAIT_HI, S_GOT_HI, S_WAIT_LO, S_GOT_LO,
        S_MUL, S_IDIV_RUN, S_FINISH, S_EMIT
    } t_state;

    t_state            r_state;
    pwlwt_pkg::t_in_word r_word;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_first, r_len;
    logic [1:0]        r_curve_i;
    logic [31:0]       r_w [3];
    logic [63:0]       r_num;   // dividend, shifted out as quotient bits enter
    logic [31:0]       r_den;
    logic [32:0]       r_rem;
    logic [6:0]        r_bit;
    logic [6:0]        r_nbits;
    logic [31:0]       r_c_hi, r_c_lo, r_w_hi, r_w_lo;
    logic              r_down;
    logic [31:0]       r_res_w;
    logic [1:0]        r_res_s;
    logic              r_out_valid;
    logic [31:0]       r_out_w;
    logic [1:0]        r_out_s;

    logic [AW-1:0]     r_raddr;
    logic [31:0]       c_rd, n_rd, p_rd, m_rd;
    logic              we;
    logic              out_free;

    assign we = (r_state == S_WRITE);
    assign out_free = !r_out_valid || o_out.ready;

    pwlwt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_c (.i_clk, .i_we(we),
        .i_waddr(r_count[AW-1:0]), .i_wdata(r_word.entry_center),
        .i_raddr(r_raddr), .o_rdata(c_rd));
    pwlwt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_n (.i_clk, .i_we(we),
        .i_waddr(r_count[AW-1:0]), .i_wdata(r_w[0]),
        .i_raddr(r_raddr), .o_rdata(n_rd));
    pwlwt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_p (.i_clk, .i_we(we),
        .i_waddr(r_count[AW-1:0]), .i_wdata(r_w[1]),
        .i_raddr(r_raddr), .o_rdata(p_rd));
    pwlwt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_m (.i_clk, .i_we(we),
        .i_waddr(r_count[AW-1:0]), .i_wdata(r_w[2]),
        .i_raddr(r_raddr), .o_rdata(m_rd));

    logic [31:0] sel_rd;
    always_comb begin
        unique case (pwlwt_pkg::t_curve'(r_word.curve_select))
            pwlwt_pkg::CURVE_NOMINAL: sel_rd = n_rd;
            pwlwt_pkg::CURVE_PLUS:    sel_rd = p_rd;
            pwlwt_pkg::CURVE_MINUS:   sel_rd = m_rd;
            default:                  sel_rd = '0;
        endcase
    end

    logic [31:0] target;
    always_comb begin
        unique case (r_curve_i)
            2'd0:    target = r_word.nominal_target;
            2'd1:    target = r_word.plus_target;
            default: target = r_word.minus_target;
        endcase
    end

    // Shared restoring divider step.
    logic [32:0] trial;
    logic [32:0] sub;
    assign trial = {r_rem[31:0], r_num[63]};
    assign sub   = trial - {1'b0, r_den};

    logic [CW-1:0] half, mid;
    assign half = r_len >> 1;
    assign mid  = r_first + half;

    logic [63:0] prod;
    assign prod = 64'(r_down ? (r_w_lo - r_w_hi) : (r_w_hi - r_w_lo)) * 64'(r_word.query_mass - r_c_lo);

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = '{weight_value: r_out_w, lookup_status: r_out_s};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The output register refills in the same cycle that its word leaves.
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_word <= i_in.payload;
                        unique case (pwlwt_pkg::t_kind'(i_in.payload.kind))
                            pwlwt_pkg::KIND_CLEAR: r_count <= '0;
                            pwlwt_pkg::KIND_APPEND: begin
                                if (r_count < CW'(TABLE_DEPTH)) begin
                                    r_curve_i <= 2'd0;
                                    r_state   <= S_DIV_SETUP;
                                end
                            end
                            pwlwt_pkg::KIND_QUERY: begin
                                if (r_count == '0) begin
                                    r_res_w <= pwlwt_pkg::ONE_Q16;
                                    r_res_s <= pwlwt_pkg::STATUS_EMPTY;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= S_RD_FIRST;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV_SETUP: begin
                    // The 48-bit dividend target * 65536 sits in the top bits.
                    r_num   <= {target, 32'd0};
                    r_den   <= r_word.initial_amount;
                    r_rem   <= '0;
                    r_bit   <= '0;
                    r_nbits <= 7'd48;
                    r_state <= S_DIV_RUN;
                end
                S_DIV_RUN, S_IDIV_RUN: begin
                    if (!sub[32]) begin
                        r_rem <= sub;
                        r_num <= {r_num[62:0], 1'b1};
                    end else begin
                        r_rem <= trial;
                        r_num <= {r_num[62:0], 1'b0};
                    end
                    r_bit <= r_bit + 7'd1;
                    if (r_bit == r_nbits - 7'd1) begin
                        r_state <= (r_state == S_DIV_RUN) ? S_DIV_STORE : S_FINISH;
                    end
                end
                S_DIV_STORE: begin
                    // Quotient sits in the low 48 bits of r_num.
                    if ($signed(r_word.initial_amount) <= 0 || $signed(target) <= 0) begin
                        r_w[r_curve_i] <= '0;
                    end else if (r_num[47:32] != '0) begin
                        r_w[r_curve_i] <= '1;
                    end else begin
                        r_w[r_curve_i] <= r_num[31:0];
                    end
                    if (r_curve_i == 2'd2) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_curve_i <= r_curve_i + 2'd1;
                        r_state   <= S_DIV_SETUP;
                    end
                end
                S_WRITE: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_IDLE;
                end
                S_RD_FIRST: begin
                    r_raddr <= '0;
                    r_state <= S_WAIT_FIRST;
                end
                S_WAIT_FIRST: begin
                    r_raddr <= AW'(r_count - CW'(1));
                    r_state <= S_CHK_FIRST;
                end
                S_CHK_FIRST: begin
                    r_c_lo  <= c_rd;
                    r_state <= S_WAIT_LAST;
                end
                S_WAIT_LAST: r_state <= S_CHK_LAST;
                S_CHK_LAST: begin
                    if (r_word.query_mass < r_c_lo || r_word.query_mass > c_rd) begin
                        r_res_w <= '0;
                        r_res_s <= pwlwt_pkg::STATUS_OUTSIDE;
                        r_state <= S_EMIT;
                    end else begin
                        r_first <= '0;
                        r_len   <= r_count;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (r_len == '0) begin
                        if (r_first >= r_count) begin
                            r_first <= r_count - CW'(1);
                        end
                        r_state <= S_RD_HI;
                    end else begin
                        r_raddr <= mid[AW-1:0];
                        r_state <= S_PROBE_WAIT;
                    end
                end
                S_PROBE_WAIT: r_state <= S_PROBE_CHK;
                S_PROBE_CHK: begin
                    if (c_rd < r_word.query_mass) begin
                        r_first <= mid + CW'(1);
                        r_len   <= r_len - half - CW'(1);
                    end else begin
                        r_len <= half;
                    end
                    r_state <= S_PROBE;
                end
                S_RD_HI: begin
                    r_raddr <= r_first[AW-1:0];
                    r_state <= S_WAIT_HI;
                end
                S_WAIT_HI: begin
                    r_raddr <= r_first[AW-1:0] - AW'(1);
                    r_state <= S_GOT_HI;
                end
                S_GOT_HI: begin
                    r_w_hi <= sel_rd;
                    r_c_hi <= c_rd;
                    r_state <= S_WAIT_LO;
                end
                S_WAIT_LO: r_state <= S_GOT_LO;
                S_GOT_LO: begin
                    r_w_lo <= sel_rd;
                    r_c_lo <= c_rd;
                    r_down <= sel_rd > r_w_hi;
                    if (r_first == '0 || r_c_hi == r_word.query_mass
                        || !(c_rd < r_word.query_mass && r_word.query_mass < r_c_hi)) begin
                        r_res_w <= r_w_hi;
                        r_res_s <= pwlwt_pkg::STATUS_IN_RANGE;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_num   <= prod;
                    r_den   <= r_c_hi - r_c_lo;
                    r_rem   <= '0;
                    r_bit   <= '0;
                    r_nbits <= 7'd64;
                    r_state <= S_IDIV_RUN;
                end
                S_FINISH: begin
                    // Offset is below |hi - lo|, so its low 32 bits suffice.
                    r_res_w <= r_down ? (r_w_lo - r_num[31:0]) : (r_w_lo + r_num[31:0]);
                    r_res_s <= pwlwt_pkg::STATUS_IN_RANGE;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_w <= r_res_w;
                        r_out_s <= r_res_s;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH)) else $error("entry count overflow");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> r_state == S_IDLE) else $error("ready while busy");
    a_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> r_count < CW'(TABLE_DEPTH)) else $error("write into full table");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid) else $error("result lost");
endmodule
